[src/pbb_pkg.sv]
// ----------------------------------------------------------------------------
// pbb_pkg
// Shared types and constants of the projected box bounds block.
// ----------------------------------------------------------------------------
package pbb_pkg;

    localparam int CorAw  = 33;   // corner coordinate, Q.8
    localparam int ClipW  = 72;   // clip value, Q.16
    localparam int NdcW   = 42;   // ndc value, signed Q.16 (magnitude up to 2^40)
    localparam int PosW   = 60;   // screen position, Q.17
    localparam int QBits  = 40;   // quotient bits produced (24 integer + 16 fraction)

    localparam logic signed [ClipW-1:0] WMinQ16 = ClipW'(65);

    typedef enum logic [2:0] {
        REG_ROW0_01 = 3'd0,
        REG_ROW0_23 = 3'd1,
        REG_ROW1_01 = 3'd2,
        REG_ROW1_23 = 3'd3,
        REG_ROW3_01 = 3'd4,
        REG_ROW3_23 = 3'd5,
        REG_SCR_W   = 3'd6,
        REG_SCR_H   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic                    vld;
        logic                    last;
        logic                    first;
        logic signed [ClipW-1:0] x;
        logic signed [ClipW-1:0] y;
        logic signed [ClipW-1:0] w;
    } t_clip;

    typedef struct packed {
        logic                   vld;
        logic                   last;
        logic                   first;
        logic                   bad;
        logic signed [PosW-1:0] sx;
        logic signed [PosW-1:0] sy;
    } t_pos;

endpackage

[src/pbb_corner.sv]
// ----------------------------------------------------------------------------
// pbb_corner
// Sequences the eight corners of one box and pipelines the clip transform:
// products registered, then sums registered.
// ----------------------------------------------------------------------------
module pbb_corner (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_take,
    input  logic signed [31:0]                i_org_x,
    input  logic signed [31:0]                i_org_y,
    input  logic signed [31:0]                i_org_z,
    input  logic signed [31:0]                i_min_x,
    input  logic signed [31:0]                i_min_y,
    input  logic signed [31:0]                i_min_z,
    input  logic signed [31:0]                i_max_x,
    input  logic signed [31:0]                i_max_y,
    input  logic signed [31:0]                i_max_z,
    input  logic signed [31:0]                i_m [3][4],
    output logic                              o_busy,
    output pbb_pkg::t_clip                    o_clip
);
    localparam int A = pbb_pkg::CorAw;
    localparam int C = pbb_pkg::ClipW;

    logic                r_act;
    logic [2:0]          r_k;
    logic signed [A-1:0] r_lo [3];
    logic signed [A-1:0] r_hi [3];

    // free again while the last corner issues
    assign o_busy = r_act && (r_k != 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_k   <= '0;
        end else if (i_take) begin
            r_act <= 1'b1;
            r_k   <= '0;
        end else if (r_act) begin
            r_k <= r_k + 3'd1;
            if (r_k == 3'd7) begin
                r_act <= 1'b0;
            end
        end
        if (i_take) begin
            r_lo[0] <= A'(i_org_x) + A'(i_min_x);
            r_lo[1] <= A'(i_org_y) + A'(i_min_y);
            r_lo[2] <= A'(i_org_z) + A'(i_min_z);
            r_hi[0] <= A'(i_org_x) + A'(i_max_x);
            r_hi[1] <= A'(i_org_y) + A'(i_max_y);
            r_hi[2] <= A'(i_org_z) + A'(i_max_z);
        end
    end

    // corner select and product stage: floor(p * m / 256)
    logic signed [A-1:0]  w_p [3];
    logic signed [C-1:0]  r_prod [3][3];
    logic signed [C-1:0]  r_off [3];
    logic                 r_v1, r_l1, r_f1;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_p[a] = r_k[a] ? r_hi[a] : r_lo[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_act;
        end
        r_l1 <= (r_k == 3'd7);
        r_f1 <= (r_k == 3'd0);
        for (int r = 0; r < 3; r++) begin
            r_off[r] <= C'(i_m[r][3]);
            for (int a = 0; a < 3; a++) begin
                r_prod[r][a] <= C'((C'(w_p[a]) * C'(i_m[r][a])) >>> 8);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_clip.vld <= 1'b0;
        end else begin
            o_clip.vld <= r_v1;
        end
        o_clip.last  <= r_l1;
        o_clip.first <= r_f1;
        o_clip.x <= r_off[0] + r_prod[0][0] + r_prod[0][1] + r_prod[0][2];
        o_clip.y <= r_off[1] + r_prod[1][0] + r_prod[1][1] + r_prod[1][2];
        o_clip.w <= r_off[2] + r_prod[2][0] + r_prod[2][1] + r_prod[2][2];
    end
endmodule

[src/pbb_div.sv]
// ----------------------------------------------------------------------------
// pbb_div
// Pipelined restoring divider: x/w and y/w in Q.16, truncated, one quotient
// bit per stage, then scaled to screen positions in Q.17.
// ----------------------------------------------------------------------------
module pbb_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [13:0]    i_scr_w,
    input  logic [13:0]    i_scr_h,
    input  pbb_pkg::t_clip i_clip,
    output pbb_pkg::t_pos  o_pos
);
    localparam int C = pbb_pkg::ClipW;
    localparam int Q = pbb_pkg::QBits;
    localparam int N = pbb_pkg::NdcW;
    localparam int P = pbb_pkg::PosW;
    localparam int S = Q + 1;
    localparam int D = C + 16;   // dividend with fraction bits

    // stage 0: magnitudes; integer ratio of 2^24 or more saturates
    logic [S-1:0]   r_vld, r_last, r_first, r_bad, r_nx, r_ny;
    logic [D-1:0]   r_ax [S], r_ay [S];
    logic [C-1:0]   r_d [S];
    logic [Q-1:0]   r_qx [S], r_qy [S];
    logic [S-1:0]   r_ovx, r_ovy;
    logic [C-1:0]   w_mag_x, w_mag_y;
    logic           w_ovx, w_ovy;

    always_comb begin
        w_mag_x = i_clip.x[C-1] ? C'(-i_clip.x) : C'(i_clip.x);
        w_mag_y = i_clip.y[C-1] ? C'(-i_clip.y) : C'(i_clip.y);
        w_ovx   = (w_mag_x >> 24) >= C'($unsigned(i_clip.w));
        w_ovy   = (w_mag_y >> 24) >= C'($unsigned(i_clip.w));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[S-2:0], i_clip.vld};
        end
        r_last  <= {r_last[S-2:0], i_clip.last};
        r_first <= {r_first[S-2:0], i_clip.first};
        r_bad   <= {r_bad[S-2:0], (i_clip.w <= pbb_pkg::WMinQ16)};
        r_nx    <= {r_nx[S-2:0], i_clip.x[C-1]};
        r_ny    <= {r_ny[S-2:0], i_clip.y[C-1]};
        r_d[0]  <= i_clip.w;
        r_ax[0] <= {w_mag_x, 16'd0};
        r_ay[0] <= {w_mag_y, 16'd0};
        r_qx[0] <= '0;
        r_qy[0] <= '0;
        r_ovx[0] <= w_ovx;
        r_ovy[0] <= w_ovy;
    end

    // quotient bit j (weight 2^(Q-1-j))
    for (genvar j = 0; j < Q; j++) begin : g_st
        localparam int Sh = Q - 1 - j;
        logic [D:0] w_tx, w_ty;
        logic       w_gx, w_gy;
        // numerator >= d<<Sh via partial remainder; remainder holds dividend
        always_comb begin
            w_tx = {1'b0, r_ax[j]} - ({1'b0, D'(r_d[j])} << Sh);
            w_ty = {1'b0, r_ay[j]} - ({1'b0, D'(r_d[j])} << Sh);
            w_gx = !w_tx[D] && ((D'(r_d[j]) << Sh) >> Sh) == D'(r_d[j]);
            w_gy = !w_ty[D] && ((D'(r_d[j]) << Sh) >> Sh) == D'(r_d[j]);
        end
        always_ff @(posedge i_clk) begin
            r_d[j+1]  <= r_d[j];
            r_ax[j+1] <= w_gx ? D'(w_tx) : r_ax[j];
            r_ay[j+1] <= w_gy ? D'(w_ty) : r_ay[j];
            r_qx[j+1] <= r_qx[j] | (Q'(w_gx) << Sh);
            r_qy[j+1] <= r_qy[j] | (Q'(w_gy) << Sh);
            r_ovx[j+1] <= r_ovx[j];
            r_ovy[j+1] <= r_ovy[j];
        end
    end

    // ndc with saturation, then register before scaling
    logic signed [N-1:0] r_ndx, r_ndy;
    logic                r_v2, r_l2, r_f2, r_b2;
    logic [N-1:0]        w_mx, w_my;

    always_comb begin
        w_mx = r_ovx[Q] ? (N'(1) << 40) : N'(r_qx[Q]);
        w_my = r_ovy[Q] ? (N'(1) << 40) : N'(r_qy[Q]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_vld[Q];
        end
        r_l2  <= r_last[Q];
        r_f2  <= r_first[Q];
        r_b2  <= r_bad[Q];
        r_ndx <= r_nx[Q] ? -$signed(w_mx) : $signed(w_mx);
        r_ndy <= r_ny[Q] ? -$signed(w_my) : $signed(w_my);
    end

    // scale: product registered, then offsets added
    logic signed [P-1:0] r_px, r_py;
    logic                r_v3, r_l3, r_f3, r_b3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_l3 <= r_l2;
        r_f3 <= r_f2;
        r_b3 <= r_b2;
        r_px <= P'(r_ndx) * P'($signed({1'b0, i_scr_w}));
        r_py <= P'(r_ndy) * P'($signed({1'b0, i_scr_h}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_pos.vld <= 1'b0;
        end else begin
            o_pos.vld <= r_v3;
        end
        o_pos.last  <= r_l3;
        o_pos.first <= r_f3;
        o_pos.bad   <= r_b3;
        o_pos.sx <= (P'(i_scr_w[13:1]) <<< 17) + r_px + P'(65536);
        o_pos.sy <= (P'(i_scr_h[13:1]) <<< 17) - r_py - P'(65536);
    end
endmodule

[src/pbb_bounds.sv]
// ----------------------------------------------------------------------------
// pbb_bounds
// Min/max over the eight corners, then difference, truncation and saturation.
// ----------------------------------------------------------------------------
module pbb_bounds (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pbb_pkg::t_pos        i_pos,
    output logic                 o_strobe,
    output logic signed [15:0]   o_left,
    output logic signed [15:0]   o_top,
    output logic [15:0]          o_width,
    output logic [15:0]          o_height,
    output logic                 o_valid
);
    localparam int P = pbb_pkg::PosW;

    logic signed [P-1:0] r_l, r_r, r_t, r_b;
    logic                r_bad, r_done;
    logic signed [P-1:0] w_l, w_r, w_t, w_b;

    always_comb begin
        w_l = (i_pos.first || i_pos.sx < r_l) ? i_pos.sx : r_l;
        w_r = (i_pos.first || i_pos.sx > r_r) ? i_pos.sx : r_r;
        w_t = (i_pos.first || i_pos.sy < r_t) ? i_pos.sy : r_t;
        w_b = (i_pos.first || i_pos.sy > r_b) ? i_pos.sy : r_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_pos.vld && i_pos.last;
        end
        if (i_pos.vld) begin
            r_l <= w_l;
            r_r <= w_r;
            r_t <= w_t;
            r_b <= w_b;
            r_bad <= i_pos.bad || (!i_pos.first && r_bad);
        end
    end

    // difference and truncation stage
    logic signed [P:0] r_dw, r_dh;
    logic signed [P-1:0] r_tl, r_tt;
    logic r_ok, r_v4;

    function automatic logic signed [P:0] f_trunc(input logic signed [P:0] v);
        logic [P:0] m;
        begin
            m = v[P] ? (P+1)'(-v) : v;
            m = m >> 17;
            f_trunc = v[P] ? -$signed(m) : $signed(m);
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_done;
        end
        r_ok <= !r_bad;
        r_tl <= P'(f_trunc((P+1)'(r_l)));
        r_tt <= P'(f_trunc((P+1)'(r_t)));
        r_dw <= f_trunc((P+1)'(r_r) - (P+1)'(r_l));
        r_dh <= f_trunc((P+1)'(r_b) - (P+1)'(r_t));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_v4;
        end
        if (!r_ok) begin
            o_left <= '0; o_top <= '0; o_width <= '0; o_height <= '0; o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b1;
            o_left <= r_tl > 32767 ? 16'sd32767 : r_tl < -32768 ? -16'sd32768 : 16'(r_tl);
            o_top  <= r_tt > 32767 ? 16'sd32767 : r_tt < -32768 ? -16'sd32768 : 16'(r_tt);
            o_width  <= r_dw > 65535 ? 16'hFFFF : r_dw < 0 ? 16'd0 : 16'(r_dw);
            o_height <= r_dh > 65535 ? 16'hFFFF : r_dh < 0 ? 16'd0 : 16'(r_dh);
        end
    end
endmodule

[src/projected_box_bounds.sv]
// ----------------------------------------------------------------------------
// projected_box_bounds
// Screen bounding rectangle of a perspective-projected 3D box.
// ----------------------------------------------------------------------------
// The eight corners of one item share one pipelined projection unit at a
// corner per cycle, so busy stays high after the accepting edge until the
// last corner issues, and the next start is taken while that corner issues.
// The result strobe follows the restoring divider (one quotient bit per
// stage) and the bounds stages; the receiver cannot stall.
module projected_box_bounds (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [31:0] i_origin_z,
    input  logic signed [31:0] i_min_off_x,
    input  logic signed [31:0] i_min_off_y,
    input  logic signed [31:0] i_min_off_z,
    input  logic signed [31:0] i_max_off_x,
    input  logic signed [31:0] i_max_off_y,
    input  logic signed [31:0] i_max_off_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    output logic               o_strobe,
    output logic signed [15:0] o_box_left,
    output logic signed [15:0] o_box_top,
    output logic [15:0]        o_box_width,
    output logic [15:0]        o_box_height,
    output logic               o_box_valid
);
    logic signed [31:0] r_m [3][4];
    logic [13:0]        r_scr_w, r_scr_h;
    logic               w_take;
    pbb_pkg::t_clip     w_clip;
    pbb_pkg::t_pos      w_pos;

    assign o_cfg_ready = 1'b1;
    assign w_take      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_m[r][c] <= '0;
                end
            end
            r_scr_w <= 14'd1920;
            r_scr_h <= 14'd1080;
        end else if (i_cfg_valid) begin
            case (pbb_pkg::t_reg_idx'(i_cfg_index))
                pbb_pkg::REG_ROW0_01: begin
                    r_m[0][0] <= i_cfg_data[31:0]; r_m[0][1] <= i_cfg_data[63:32];
                end
                pbb_pkg::REG_ROW0_23: begin
                    r_m[0][2] <= i_cfg_data[31:0]; r_m[0][3] <= i_cfg_data[63:32];
                end
                pbb_pkg::REG_ROW1_01: begin
                    r_m[1][0] <= i_cfg_data[31:0]; r_m[1][1] <= i_cfg_data[63:32];
                end
                pbb_pkg::REG_ROW1_23: begin
                    r_m[1][2] <= i_cfg_data[31:0]; r_m[1][3] <= i_cfg_data[63:32];
                end
                pbb_pkg::REG_ROW3_01: begin
                    r_m[2][0] <= i_cfg_data[31:0]; r_m[2][1] <= i_cfg_data[63:32];
                end
                pbb_pkg::REG_ROW3_23: begin
                    r_m[2][2] <= i_cfg_data[31:0]; r_m[2][3] <= i_cfg_data[63:32];
                end
                pbb_pkg::REG_SCR_W: begin
                    r_scr_w <= i_cfg_data[13:0];
                end
                pbb_pkg::REG_SCR_H: begin
                    r_scr_h <= i_cfg_data[13:0];
                end
                default: begin
                end
            endcase
        end
    end

    pbb_corner u_corner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_org_x (i_origin_x),
        .i_org_y (i_origin_y),
        .i_org_z (i_origin_z),
        .i_min_x (i_min_off_x),
        .i_min_y (i_min_off_y),
        .i_min_z (i_min_off_z),
        .i_max_x (i_max_off_x),
        .i_max_y (i_max_off_y),
        .i_max_z (i_max_off_z),
        .i_m     (r_m),
        .o_busy  (busy),
        .o_clip  (w_clip)
    );

    pbb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scr_w (r_scr_w),
        .i_scr_h (r_scr_h),
        .i_clip  (w_clip),
        .o_pos   (w_pos)
    );

    pbb_bounds u_bounds (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pos    (w_pos),
        .o_strobe (o_strobe),
        .o_left   (o_box_left),
        .o_top    (o_box_top),
        .o_width  (o_box_width),
        .o_height (o_box_height),
        .o_valid  (o_box_valid)
    );
endmodule
